FILE: rtl/mwsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwsm_pkg
// Types and fixed widths shared by the moving-window sum and mean block.
// ----------------------------------------------------------------------------
package mwsm_pkg;

  // Field widths of the transactions
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SUM_W    = 42;
  localparam int unsigned MEAN_W   = 32;
  localparam int unsigned WIN_W    = 11;

  // Configuration port
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_WINDOW_LENGTH = 1'b0;  // register index bit

  // Bit-serial divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Mean saturation limits, held at sum width
  localparam logic signed [SUM_W-1:0] MEAN_MAX =
    SUM_W'((64'd1 << (MEAN_W - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] MEAN_MIN = -MEAN_MAX - SUM_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_series;
  } mwsm_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  window_sum;
    logic signed [MEAN_W-1:0] window_mean;
  } mwsm_out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // capture input transaction, read oldest ring entry
    logic upd_sub;   // drop oldest / bump count, write ring, advance pointer
    logic upd_add;   // add new sample to running sum
    logic div_load;  // snapshot sum and count, prime divider, clear on last
    logic div_step;  // one restoring division step
    logic out_load;  // load output register
  } mwsm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;  // final division step under way
  } mwsm_sts_t;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SUB  = 6'b000010,
    ST_ADD  = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } mwsm_state_e;

endpackage

FILE: rtl/mwsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwsm_ctrl
// Sequencer for one sample: ring read, sum update, division, result hand-off.
// ----------------------------------------------------------------------------
module mwsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mwsm_pkg::mwsm_cmd_t cmd_o,
  input  mwsm_pkg::mwsm_sts_t sts_i
);
  import mwsm_pkg::*;

  mwsm_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // Output register may be refilled when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SUB;
        end
      end
      ST_SUB: begin
        cmd_o.upd_sub = 1'b1;
        state_d       = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.upd_add = 1'b1;
        state_d       = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/mwsm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwsm_dp
// Sample ring, running sum, window count and bit-serial signed divider.
// ----------------------------------------------------------------------------
module mwsm_dp #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mwsm_pkg::mwsm_in_t       in_data_i,
  input  logic [mwsm_pkg::WIN_W-1:0] win_i,   // effective window, 1..MAX_WINDOW
  input  mwsm_pkg::mwsm_cmd_t      cmd_i,
  output mwsm_pkg::mwsm_sts_t      sts_o,
  output mwsm_pkg::mwsm_out_t      out_data_o
);
  import mwsm_pkg::*;

  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned IDX_W = PTR_W + 1;
  localparam logic [IDX_W-1:0] DEPTH    = IDX_W'(MAX_WINDOW);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_WINDOW - 1);

  // Ring of samples
  logic signed [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] oldest_q;

  // Captured transaction
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;

  // Series state
  logic [PTR_W-1:0]        wp_q, wp_d;
  logic [WIN_W-1:0]        seen_q, seen_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;

  // Divider
  logic [SUM_W-1:0]        quo_q;
  logic [WIN_W-1:0]        rem_q;
  logic [WIN_W-1:0]        dvs_q;
  logic [DIV_CNT_W-1:0]    cnt_q;
  logic                    neg_q;
  logic signed [SUM_W-1:0] res_sum_q;
  logic [WIN_W:0]          trial;
  logic                    trial_ge;

  // Result
  mwsm_out_t               out_q;
  logic signed [SUM_W-1:0] mean_full;
  logic signed [MEAN_W-1:0] mean_sat;

  // Oldest entry: (wp + MAX_WINDOW - w) mod MAX_WINDOW, range below 2*MAX_WINDOW
  logic [IDX_W-1:0] idx_raw;
  logic [IDX_W-1:0] idx_mod;
  logic             full;

  assign idx_raw = IDX_W'(wp_q) + DEPTH - IDX_W'(win_i);
  assign idx_mod = (idx_raw >= DEPTH) ? (idx_raw - DEPTH) : idx_raw;
  assign full    = (seen_q >= win_i);

  // Ring memory: read on accept, write during the sum update
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      oldest_q <= ring_mem[idx_mod[PTR_W-1:0]];
    end
    if (cmd_i.upd_sub) begin
      ring_mem[wp_q] <= sample_q;
    end
  end

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= in_data_i.sample;
      last_q   <= in_data_i.last_in_series;
    end
  end

  // Running sum, count and write pointer
  always_comb begin
    wp_d   = wp_q;
    seen_d = seen_q;
    sum_d  = sum_q;
    if (cmd_i.upd_sub) begin
      wp_d = (wp_q == LAST_PTR) ? '0 : wp_q + PTR_W'(1);
      if (full) begin
        sum_d  = sum_q - SUM_W'(oldest_q);
        seen_d = win_i;
      end else begin
        seen_d = seen_q + WIN_W'(1);
      end
    end
    if (cmd_i.upd_add) begin
      sum_d = sum_q + SUM_W'(sample_q);
    end
    // End of series clears after the snapshot for the divider
    if (cmd_i.div_load && last_q) begin
      wp_d   = '0;
      seen_d = '0;
      sum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      seen_q <= '0;
      sum_q  <= '0;
    end else begin
      wp_q   <= wp_d;
      seen_q <= seen_d;
      sum_q  <= sum_d;
    end
  end

  // Restoring division on magnitudes, one quotient bit per step
  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      res_sum_q <= sum_q;
      neg_q     <= sum_q[SUM_W-1];
      quo_q     <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      rem_q     <= '0;
      dvs_q     <= seen_q;
      cnt_q     <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? WIN_W'(trial - {1'b0, dvs_q}) : WIN_W'(trial);
      quo_q <= {quo_q[SUM_W-2:0], trial_ge};
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  assign sts_o.div_done = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  // Sign restore and saturation to the mean range
  assign mean_full = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_comb begin
    if (mean_full > MEAN_MAX) begin
      mean_sat = MEAN_W'(MEAN_MAX);
    end else if (mean_full < MEAN_MIN) begin
      mean_sat = MEAN_W'(MEAN_MIN);
    end else begin
      mean_sat = MEAN_W'(mean_full);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.window_sum  <= res_sum_q;
      out_q.window_mean <= mean_sat;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: rtl/moving_window_sum_and_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_window_sum_and_mean
// Moving-window sum and mean over signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result: the exact 42-bit sum of the newest
// min(count, window) samples and that sum divided by the count, truncated
// toward zero and saturated to 32 bits. One sample is processed at a time:
// it is accepted and the oldest ring entry read, then the sum is updated and
// the divider primed (states SUB, ADD and LOAD), the bit-serial divider runs
// (one quotient bit per cycle) and the result is loaded into the output
// register once that register is free. The next sample is taken while a
// result still waits downstream. A sample flagged last_in_series clears the
// window after its result. Write window_length (byte address 0) between
// series; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module moving_window_sum_and_mean #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mwsm_pkg::mwsm_in_t            in_data_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mwsm_pkg::mwsm_out_t           out_data_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwsm_pkg::PADDR_W-1:0]  paddr,
  input  logic [mwsm_pkg::PDATA_W-1:0]  pwdata,
  output logic [mwsm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import mwsm_pkg::*;

  logic [WIN_W-1:0] win_len_q, win_len_d;
  logic [WIN_W-1:0] win_eff;
  logic             reg_sel;
  mwsm_cmd_t        cmd;
  mwsm_sts_t        sts;

  // Register write
  assign reg_sel = (paddr[2] == REG_WINDOW_LENGTH);
  assign pready  = 1'b1;

  always_comb begin
    win_len_d = win_len_q;
    if (psel && penable && pwrite && reg_sel) begin
      win_len_d = pwdata[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WIN_W'(1);
    end else begin
      win_len_q <= win_len_d;
    end
  end

  // Register read
  assign prdata = reg_sel ? PDATA_W'(win_len_q) : '0;

  // Effective window: zero reads as one, clamped to the ring depth
  always_comb begin
    if (win_len_q == '0) begin
      win_eff = WIN_W'(1);
    end else if (32'(win_len_q) > 32'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = win_len_q;
    end
  end

  mwsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mwsm_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .win_i      (win_eff),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

FILE: tb/sv/tb_moving_window_sum_and_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_window_sum_and_mean
// Self-checking bench for the moving-window sum and mean block.
// ----------------------------------------------------------------------------
// Q16.16 samples are streamed through the valid/stall input channel. Each
// accepted transaction is run through a cycle-free model of the window (ring,
// count, running sum, truncating divide with saturation) and the expected
// result is queued. Every result leaving the block is compared field by field
// with the oldest queued one. The window length is written over the APB port
// while nothing is in flight; some series run on across a window change.
// Both sides insert random gaps, with some phases running back to back.
// ----------------------------------------------------------------------------
module tb_moving_window_sum_and_mean;
  import mwsm_pkg::*;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_SAMPLES = 550;
  localparam int unsigned DRAIN_CYCLES = 60;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam longint MEAN_HI = (longint'(1) << (MEAN_W - 1)) - 1;
  localparam longint MEAN_LO = -MEAN_HI - 1;

  // Window model and queue of outstanding results
  class window_scoreboard;
    logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
    logic [RING_AW-1:0]         wr_pos;
    logic [WIN_W-1:0]           seen;
    logic [WIN_W-1:0]           window;
    logic signed [SUM_W-1:0]    acc;
    mwsm_out_t                  expected_q [$];
    int                         failures;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_pos   = '0;
      seen     = '0;
      acc      = '0;
      window   = WIN_W'(1);
      failures = 0;
    endfunction

    function void set_window(logic [WIN_W-1:0] value);
      window = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // One step of the window: drop oldest when full, add newest, divide
    function mwsm_out_t predict_window(mwsm_in_t item);
      logic [WIN_W-1:0]           eff;
      logic [RING_AW-1:0]         oldest_pos;
      logic signed [SAMPLE_W-1:0] oldest;
      longint                     quo;
      mwsm_out_t                  res;

      // zero acts as 1, anything over the ring depth as the full ring
      if (window == 0) eff = WIN_W'(1);
      else if (window > RING_DEPTH) eff = WIN_W'(RING_DEPTH);
      else eff = window;

      oldest_pos = wr_pos - eff[RING_AW-1:0];
      oldest     = ring[oldest_pos];
      if (seen >= eff) begin
        acc  = acc - oldest;
        seen = eff;
      end else begin
        seen = seen + 1'b1;
      end
      acc          = acc + item.sample;  // wraps at sum width
      ring[wr_pos] = item.sample;
      wr_pos       = wr_pos + 1'b1;

      quo = longint'(acc) / longint'(seen);
      if (quo > MEAN_HI) quo = MEAN_HI;
      if (quo < MEAN_LO) quo = MEAN_LO;

      res.window_sum  = acc;
      res.window_mean = quo[MEAN_W-1:0];

      // end of series clears the window
      if (item.last_in_series) begin
        wr_pos = '0;
        seen   = '0;
        acc    = '0;
      end
      return res;
    endfunction

    function void note_sample(mwsm_in_t item);
      expected_q.push_back(predict_window(item));
    endfunction

    function void check_result(mwsm_out_t got);
      mwsm_out_t exp_res;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with nothing pending: sum %0d mean %0d",
                   $realtime, got.window_sum, got.window_mean);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.window_sum !== exp_res.window_sum ||
          got.window_mean !== exp_res.window_mean) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch: sum exp %0d got %0d, mean exp %0d got %0d",
                   $realtime, exp_res.window_sum, got.window_sum,
                   exp_res.window_mean, got.window_mean);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  mwsm_in_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  mwsm_out_t            out_data_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  window_scoreboard sb = new();
  logic             back_to_back = 1'b0;
  int               stall_left = 0;
  int unsigned      cycle_count = 0;

  moving_window_sum_and_mean i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result monitor; also draws how long the next result is held off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        stall_left = back_to_back ? 0 : $urandom_range(0, 6);
      end else if (out_valid_o && out_stall_i && stall_left != 0) begin
        stall_left = stall_left - 1;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (stall_left != 0);
  end

  // Present one sample after a random gap and wait for its transaction
  task automatic send_sample(logic signed [SAMPLE_W-1:0] value, logic last);
    mwsm_in_t item;
    int       gap;
    item.sample         = value;
    item.last_in_series = last;
    gap = back_to_back ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(item);
  endtask

  // Hold off the sender until every outstanding result is out
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of the window length, only with the block idle
  task automatic write_window(logic [WIN_W-1:0] value);
    wait_for_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WINDOW_LENGTH, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!(psel && penable && pwrite && pready));
    sb.set_window(value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_W'($urandom_range(0, 512)) - SAMPLE_W'(256);
      default: return $urandom;
    endcase
  endfunction

  // Extremes, truncation of negative means and out-of-range windows
  task automatic run_directed();
    // reset window of one
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(32'sh12345678, 1'b1);

    // full window of extremes, then a negative odd sum over two
    write_window(WIN_W'(4));
    repeat (4) send_sample(SAMPLE_MAX, 1'b0);
    repeat (3) send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(-7, 1'b0);
    send_sample(2, 1'b1);

    // zero acts as a window of one
    write_window('0);
    send_sample(5, 1'b0);
    send_sample(-9, 1'b1);

    // above the ring depth, clamped to the full ring
    write_window({WIN_W{1'b1}});
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(1, 1'b1);
  endtask

  // Phases of random series; some run on across a window change
  task automatic run_random();
    int               sent;
    int               len;
    logic [WIN_W-1:0] win;
    logic             last;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 9))
        0:       win = '0;
        1:       win = WIN_W'($urandom_range(RING_DEPTH, (1 << WIN_W) - 1));
        2:       win = WIN_W'($urandom_range(13, 64));
        3:       win = WIN_W'(1);
        default: win = WIN_W'($urandom_range(1, 12));
      endcase
      write_window(win);
      back_to_back = ($urandom_range(0, 3) == 0);
      if (win > 12 || win == 0) len = $urandom_range(10, 40);
      else len = $urandom_range(2, 4 * win + 8);
      for (int i = 0; i < len; i++) begin
        last = ($urandom_range(0, 29) == 0) ||
               (i == len - 1 && $urandom_range(0, 9) < 7);
        send_sample(rand_sample(), last);
        sent++;
        // occasional full pause of the sender mid-series
        if (i == len / 2 && $urandom_range(0, 5) == 0) wait_for_results();
      end
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    // sender holds off until the block has emptied
    wait_for_results();
    run_random();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
